@@ rtl/psfm_pkg.sv @@
// ----------------------------------------------------------------------------
// psfm_pkg
// Shared types and constants for the planar span fill mask generator.
// ----------------------------------------------------------------------------
package psfm_pkg;

  localparam int unsigned SCREEN_WIDTH_DEF   = 320;
  localparam int unsigned SCREEN_HEIGHT_DEF  = 200;
  localparam int unsigned BYTES_PER_LINE_DEF = 160;

  localparam int unsigned AddrWidth  = 24;
  localparam int unsigned XWidth     = 11;
  localparam int unsigned RowWidth   = 10;
  localparam int unsigned ColWidth   = 4;
  localparam int unsigned MaskWidth  = 16;
  localparam int unsigned GroupBytes = 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic setup;
    logic advance;
  } dp_cmd_t;

  typedef struct packed {
    logic span_ok;
    logic at_last;
  } dp_status_t;

endpackage

@@ rtl/psfm_ctrl.sv @@
// ----------------------------------------------------------------------------
// psfm_ctrl
// Sequencer: accepts one span, sets up its line address, then steps through
// the 16-pixel groups one output transaction at a time.
// ----------------------------------------------------------------------------
module psfm_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  input  psfm_pkg::dp_status_t   status_i,
  output psfm_pkg::dp_cmd_t      cmd_o
);

  psfm_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= psfm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      psfm_pkg::ST_IDLE: begin
        if (in_valid_i && status_i.span_ok) begin
          state_d = psfm_pkg::ST_SETUP;
        end
      end
      psfm_pkg::ST_SETUP: begin
        state_d = psfm_pkg::ST_EMIT;
      end
      psfm_pkg::ST_EMIT: begin
        if (!out_stall_i && status_i.at_last) begin
          state_d = psfm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = psfm_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall_o    = 1'b1;
    out_valid_o   = 1'b0;
    cmd_o.load    = 1'b0;
    cmd_o.setup   = 1'b0;
    cmd_o.advance = 1'b0;
    case (state_q)
      psfm_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      psfm_pkg::ST_SETUP: begin
        cmd_o.setup = 1'b1;
      end
      psfm_pkg::ST_EMIT: begin
        out_valid_o   = 1'b1;
        cmd_o.advance = !out_stall_i && !status_i.at_last;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

@@ rtl/psfm_datapath.sv @@
// ----------------------------------------------------------------------------
// psfm_datapath
// Clipping, line address, group counter and edge mask generation.
// ----------------------------------------------------------------------------
module psfm_datapath #(
  parameter int unsigned SCREEN_WIDTH   = psfm_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT  = psfm_pkg::SCREEN_HEIGHT_DEF,
  parameter int unsigned BYTES_PER_LINE = psfm_pkg::BYTES_PER_LINE_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [psfm_pkg::AddrWidth-1:0]      cfg_wdata_i,
  input  logic [psfm_pkg::XWidth-1:0]         span_start_x_i,
  input  logic [psfm_pkg::XWidth-1:0]         span_end_x_i,
  input  logic [psfm_pkg::RowWidth-1:0]       span_row_i,
  input  logic [psfm_pkg::ColWidth-1:0]       colour_i,
  input  psfm_pkg::dp_cmd_t                   cmd_i,
  output psfm_pkg::dp_status_t                status_o,
  output logic [psfm_pkg::AddrWidth-1:0]      word_address_o,
  output logic [psfm_pkg::MaskWidth-1:0]      pixel_mask_o,
  output logic [psfm_pkg::ColWidth-1:0]       plane_enable_o,
  output logic                                last_o
);

  localparam int unsigned XW  = ($clog2(SCREEN_WIDTH) > 5) ? $clog2(SCREEN_WIDTH) : 5;
  localparam int unsigned GW  = XW - 4;
  localparam int unsigned RW  = ($clog2(SCREEN_HEIGHT) > 1) ? $clog2(SCREEN_HEIGHT) : 1;
  localparam int unsigned AW  = psfm_pkg::AddrWidth;
  localparam int unsigned MW  = psfm_pkg::MaskWidth;
  localparam logic [psfm_pkg::XWidth-1:0]   LastCol   = psfm_pkg::XWidth'(SCREEN_WIDTH - 1);
  localparam logic [psfm_pkg::RowWidth:0]   RowLimit  = (psfm_pkg::RowWidth + 1)'(SCREEN_HEIGHT);
  localparam logic [AW-1:0]                 LineBytes = AW'(BYTES_PER_LINE);
  localparam logic [AW-1:0]                 GroupStep = AW'(psfm_pkg::GroupBytes);
  localparam logic [MW-1:0]                 FullMask  = '1;

  logic [AW-1:0]               frame_base_q;
  logic [XW-1:0]               xs_q;
  logic [XW-1:0]               xe_q;
  logic [AW-1:0]               row_off_q;
  logic [psfm_pkg::ColWidth-1:0] colour_q;
  logic [GW-1:0]               grp_q, grp_d;
  logic [AW-1:0]               addr_q, addr_d;

  logic [psfm_pkg::XWidth-1:0] xs_clip;
  logic [psfm_pkg::XWidth-1:0] xe_clip;
  logic                        row_ok;
  logic                        span_empty;
  logic [RW-1:0]               row_sel;
  logic [GW-1:0]               gs;
  logic [GW-1:0]               ge;
  logic [MW-1:0]               head_mask;
  logic [MW-1:0]               tail_mask;
  logic [3:0]                  tail_shift;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_base_q <= '0;
    end else if (cfg_we_i) begin
      frame_base_q <= cfg_wdata_i;
    end
  end

  assign xs_clip = span_start_x_i[psfm_pkg::XWidth-1] ? '0 : span_start_x_i;
  assign xe_clip = ($signed(span_end_x_i) > $signed(LastCol)) ? LastCol : span_end_x_i;
  assign span_empty = $signed(xs_clip) > $signed(xe_clip);
  assign row_ok = !span_row_i[psfm_pkg::RowWidth-1]
                  && ({1'b0, span_row_i} < RowLimit);
  assign row_sel = span_row_i[RW-1:0];

  assign status_o.span_ok = row_ok && !span_empty;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      xs_q      <= xs_clip[XW-1:0];
      xe_q      <= xe_clip[XW-1:0];
      row_off_q <= AW'(row_sel) * LineBytes;
      colour_q  <= colour_i;
    end
  end

  assign gs = xs_q[XW-1:4];
  assign ge = xe_q[XW-1:4];

  always_comb begin
    grp_d  = grp_q;
    addr_d = addr_q;
    if (cmd_i.setup) begin
      grp_d  = gs;
      addr_d = frame_base_q + row_off_q + (AW'(gs) << 3);
    end else if (cmd_i.advance) begin
      grp_d  = grp_q + GW'(1);
      addr_d = addr_q + GroupStep;
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q  <= grp_d;
    addr_q <= addr_d;
  end

  assign status_o.at_last = (grp_q == ge);

  assign tail_shift = 4'd15 - xe_q[3:0];
  assign head_mask  = (grp_q == gs) ? (FullMask >> xs_q[3:0]) : FullMask;
  assign tail_mask  = (grp_q == ge) ? (FullMask << tail_shift) : FullMask;

  assign word_address_o = addr_q;
  assign pixel_mask_o   = head_mask & tail_mask;
  assign plane_enable_o = colour_q;
  assign last_o         = status_o.at_last;

endmodule

@@ rtl/planar_span_fill_masks.sv @@
// ----------------------------------------------------------------------------
// planar_span_fill_masks
// Turns horizontal span requests into masked group writes for an interleaved
// four-plane frame buffer.
// ----------------------------------------------------------------------------
// Input channel: one span transaction (start x, end x, row, colour) is taken
// when in_valid_i is high and in_stall_o is low. The span is clipped to the
// screen; an off-screen row or an empty span produces no output and the
// block is ready again in the next cycle.
// Output channel: one write transaction per 16-pixel group, left to right,
// with byte address, trimmed pixel mask, plane enables and last marker,
// taken when out_valid_o is high and out_stall_i is low.
// The first group appears in the ST_EMIT state, entered through ST_SETUP
// after the span is taken. Only one span is handled at a time; the single
// group counter steps once per output transaction. A stall on the output
// holds the current group and its payload, and holds off the next span.
// Reset clears the sequencer and sets frame_base to zero. frame_base is
// written through cfg_we_i / cfg_wdata_i; the user must write it only while
// the block is idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module planar_span_fill_masks #(
  parameter int unsigned SCREEN_WIDTH   = psfm_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT  = psfm_pkg::SCREEN_HEIGHT_DEF,
  parameter int unsigned BYTES_PER_LINE = psfm_pkg::BYTES_PER_LINE_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [psfm_pkg::AddrWidth-1:0]      cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [psfm_pkg::XWidth-1:0]         span_start_x_i,
  input  logic [psfm_pkg::XWidth-1:0]         span_end_x_i,
  input  logic [psfm_pkg::RowWidth-1:0]       span_row_i,
  input  logic [psfm_pkg::ColWidth-1:0]       colour_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [psfm_pkg::AddrWidth-1:0]      word_address_o,
  output logic [psfm_pkg::MaskWidth-1:0]      pixel_mask_o,
  output logic [psfm_pkg::ColWidth-1:0]       plane_enable_o,
  output logic                                last_o
);

  psfm_pkg::dp_cmd_t    cmd;
  psfm_pkg::dp_status_t status;

  psfm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  psfm_datapath #(
    .SCREEN_WIDTH   (SCREEN_WIDTH),
    .SCREEN_HEIGHT  (SCREEN_HEIGHT),
    .BYTES_PER_LINE (BYTES_PER_LINE)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .span_start_x_i (span_start_x_i),
    .span_end_x_i   (span_end_x_i),
    .span_row_i     (span_row_i),
    .colour_i       (colour_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .word_address_o (word_address_o),
    .pixel_mask_o   (pixel_mask_o),
    .plane_enable_o (plane_enable_o),
    .last_o         (last_o)
  );

endmodule

@@ verif/planar_span_fill_masks_tb.sv @@
// ----------------------------------------------------------------------------
// planar_span_fill_masks_tb
// Self-checking bench for the planar span fill mask generator. Spans are
// driven on the input channel. A local model turns every accepted span into
// its group writes: clipped to the screen, with edge-trimmed masks, wrapped
// addresses and a last marker. Every write taken from the output channel is
// checked against the oldest outstanding one. Both channels idle at random.
// Directed spans cover the edges and the off-screen cases, and random phases
// under several frame bases follow.
// ----------------------------------------------------------------------------
module planar_span_fill_masks_tb;

  localparam int ScreenW       = psfm_pkg::SCREEN_WIDTH_DEF;
  localparam int ScreenH       = psfm_pkg::SCREEN_HEIGHT_DEF;
  localparam int LineBytes     = psfm_pkg::BYTES_PER_LINE_DEF;
  localparam int DrainPad      = 24;
  localparam int WatchdogLimit = 2000;
  localparam int ReportLimit   = 10;

  typedef struct packed {
    logic [psfm_pkg::AddrWidth-1:0] addr;
    logic [psfm_pkg::MaskWidth-1:0] mask;
    logic [psfm_pkg::ColWidth-1:0]  planes;
    logic                           last;
  } group_write_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [psfm_pkg::AddrWidth-1:0] cfg_wdata_i = '0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  logic [psfm_pkg::XWidth-1:0]    span_start_x_i = '0;
  logic [psfm_pkg::XWidth-1:0]    span_end_x_i = '0;
  logic [psfm_pkg::RowWidth-1:0]  span_row_i = '0;
  logic [psfm_pkg::ColWidth-1:0]  colour_i = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic [psfm_pkg::AddrWidth-1:0] word_address_o;
  logic [psfm_pkg::MaskWidth-1:0] pixel_mask_o;
  logic [psfm_pkg::ColWidth-1:0]  plane_enable_o;
  logic                           last_o;

  group_write_t                   pending_writes[$];
  logic [psfm_pkg::AddrWidth-1:0] model_frame_base = '0;
  int                             mismatch_count = 0;
  int                             quiet_cycles = 0;
  int                             stall_left = 0;
  bit                             idle_en = 1'b1;

  planar_span_fill_masks dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .span_start_x_i (span_start_x_i),
    .span_end_x_i   (span_end_x_i),
    .span_row_i     (span_row_i),
    .colour_i       (colour_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .word_address_o (word_address_o),
    .pixel_mask_o   (pixel_mask_o),
    .plane_enable_o (plane_enable_o),
    .last_o         (last_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void predict_span_writes(input logic [10:0] sx, input logic [10:0] ex,
                                              input logic [9:0] row_v, input logic [3:0] col);
    int xs;
    int xe;
    int row;
    int gs;
    int ge;
    logic [15:0] mask;
    logic [15:0] rmask;
    logic [31:0] addr;
    group_write_t wr;
    xs  = $signed(sx);
    xe  = $signed(ex);
    row = $signed(row_v);
    if (row < 0 || row >= ScreenH) return;
    if (xs < 0) xs = 0;
    if (xe > ScreenW - 1) xe = ScreenW - 1;
    if (xs > xe) return;
    gs = xs >> 4;
    ge = xe >> 4;
    for (int g = gs; g <= ge; g++) begin
      mask = 16'hFFFF;
      if (g == gs) mask = mask & (16'hFFFF >> xs[3:0]);
      if (g == ge) begin
        rmask = 16'hFFFF << (15 - xe[3:0]);
        mask  = mask & rmask;
      end
      addr      = model_frame_base + row * LineBytes + g * 8;
      wr.addr   = addr[23:0];
      wr.mask   = mask;
      wr.planes = col;
      wr.last   = (g == ge);
      pending_writes.push_back(wr);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idle_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [10:0] rand_column();
    int k;
    int v;
    k = $urandom_range(0, 99);
    if (k < 75) v = $urandom_range(0, ScreenW - 1);
    else if (k < 83) v = $urandom_range(0, 40) - 20;
    else if (k < 90) v = $urandom_range(ScreenW - 20, ScreenW + 20);
    else v = $urandom;
    return v[10:0];
  endfunction

  // hold the payload until taken; leave valid high for a back-to-back transaction
  task automatic send_span(input logic [10:0] sx, input logic [10:0] ex,
                           input logic [9:0] row_v, input logic [3:0] col);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    span_start_x_i <= sx;
    span_end_x_i   <= ex;
    span_row_i     <= row_v;
    colour_i       <= col;
    do @(posedge clk_i); while (in_stall_o);
    predict_span_writes(sx, ex, row_v, col);
  endtask

  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (DrainPad) @(posedge clk_i);
  endtask

  task automatic write_frame_base(input logic [23:0] base);
    settle_block();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= base;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    model_frame_base = base;
  endtask

  task automatic test_directed_spans();
    idle_en = 1'b1;
    write_frame_base(24'h000000);
    send_span(11'd0,     11'd319,  10'd0,    4'hF);
    send_span(11'd0,     11'd0,    10'd1,    4'h1);
    send_span(11'd319,   11'd319,  10'd2,    4'h2);
    send_span(11'd5,     11'd9,    10'd3,    4'h4);
    send_span(11'd15,    11'd16,   10'd4,    4'h8);
    send_span(11'h400,   11'h3FF,  10'd199,  4'hA);
    send_span(-11'sd1,   11'd20,   10'd50,   4'h5);
    send_span(11'd300,   11'd1023, 10'd60,   4'h3);
    send_span(11'd10,    11'd20,   -10'sd1,  4'hF);
    send_span(11'd10,    11'd20,   10'd200,  4'hF);
    send_span(11'd10,    11'd20,   10'h200,  4'hF);
    send_span(11'd10,    11'd20,   10'h1FF,  4'hF);
    send_span(11'd100,   11'd50,   10'd70,   4'h6);
    send_span(11'd320,   11'd400,  10'd80,   4'h9);
    send_span(11'h400,   -11'sd1,  10'd90,   4'hC);
    send_span(11'd32,    11'd47,   10'd100,  4'h0);
    send_span(11'h3FF,   11'h3FF,  10'd110,  4'h7);
    send_span(11'd1,     11'd318,  10'd120,  4'hE);
    send_span(11'd16,    11'd16,   10'd130,  4'hB);
    send_span(11'd17,    11'd30,   10'd140,  4'hD);
    send_span(11'h400,   11'h400,  10'd150,  4'h1);
  endtask

  task automatic test_address_wrap();
    idle_en = 1'b0;
    write_frame_base(24'hFFFFFF);
    send_span(11'd0,     11'd319,  10'd199,  4'hF);
    send_span(11'd0,     11'd319,  10'd0,    4'h3);
    send_span(11'd200,   11'd250,  10'd100,  4'hC);
    write_frame_base(24'hFF8000);
    send_span(11'h400,   11'h3FF,  10'd199,  4'h5);
    send_span(11'd7,     11'd7,    10'd198,  4'hA);
  endtask

  task automatic test_random_spans(input int count, input logic [23:0] base, input bit idle);
    logic [10:0] sx;
    logic [10:0] ex;
    logic [10:0] tmp;
    logic [9:0]  row_v;
    int          r;
    write_frame_base(base);
    idle_en = idle;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 85) row_v = 10'($urandom_range(0, ScreenH - 1));
      else row_v = 10'($urandom);
      sx = rand_column();
      ex = rand_column();
      if ($urandom_range(0, 9) != 0 && $signed(sx) > $signed(ex)) begin
        tmp = sx;
        sx  = ex;
        ex  = tmp;
      end
      send_span(sx, ex, row_v, 4'($urandom));
    end
  endtask

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left  = stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (idle_en && $urandom_range(0, 99) < 25) begin
      if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(8, 40) - 1;
      else stall_left = $urandom_range(1, 3) - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    group_write_t wr;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_writes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportLimit)
          $display("unexpected write: addr %h mask %h planes %h last %b",
                   word_address_o, pixel_mask_o, plane_enable_o, last_o);
      end else begin
        wr = pending_writes.pop_front();
        if (wr.addr !== word_address_o || wr.mask !== pixel_mask_o ||
            wr.planes !== plane_enable_o || wr.last !== last_o) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit)
            $display("write mismatch: exp %h/%h/%h/%b got %h/%h/%h/%b",
                     wr.addr, wr.mask, wr.planes, wr.last,
                     word_address_o, pixel_mask_o, plane_enable_o, last_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_spans();
    test_address_wrap();
    test_random_spans(70, 24'($urandom), 1'b1);
    test_random_spans(70, 24'h000000, 1'b0);
    test_random_spans(70, 24'hFFFFFF, 1'b1);
    test_random_spans(60, 24'h555555, 1'b1);
    settle_block();
    if (mismatch_count == 0 && pending_writes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/psfm_pkg.sv
rtl/psfm_ctrl.sv
rtl/psfm_datapath.sv
rtl/planar_span_fill_masks.sv
verif/planar_span_fill_masks_tb.sv
